[src/lwf_pkg.sv]
// ----------------------------------------------------------------------------
// lwf_pkg
// Shared screen size, request and command codes, word types and helpers for
// the display window fill command engine.
// ----------------------------------------------------------------------------
package lwf_pkg;

  localparam int SCREEN_WIDTH  = 320;
  localparam int SCREEN_HEIGHT = 480;

  localparam int MAX_DIM = (SCREEN_WIDTH > SCREEN_HEIGHT) ? SCREEN_WIDTH : SCREEN_HEIGHT;
  localparam int COORD_W = $clog2(MAX_DIM + 1);
  localparam int PIX_W   = $clog2(SCREEN_WIDTH * SCREEN_HEIGHT + 1);

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [PIX_W-1:0]   pix_cnt_t;

  // request codes
  localparam logic [1:0] REQ_FILL = 2'd0;
  localparam logic [1:0] REQ_TICK = 2'd1;
  localparam logic [1:0] REQ_ROT  = 2'd2;
  localparam logic [1:0] REQ_INV  = 2'd3;

  // operation kinds
  localparam logic [1:0] KIND_FILL = 2'd0;
  localparam logic [1:0] KIND_ROT  = 2'd2;
  localparam logic [1:0] KIND_INV  = 2'd3;

  // fill sequence phases
  localparam logic [3:0] PH_COL_CMD  = 4'd0;
  localparam logic [3:0] PH_COL_SH   = 4'd1;
  localparam logic [3:0] PH_COL_SL   = 4'd2;
  localparam logic [3:0] PH_COL_EH   = 4'd3;
  localparam logic [3:0] PH_COL_EL   = 4'd4;
  localparam logic [3:0] PH_PAGE_CMD = 4'd5;
  localparam logic [3:0] PH_ROW_SH   = 4'd6;
  localparam logic [3:0] PH_ROW_SL   = 4'd7;
  localparam logic [3:0] PH_ROW_EH   = 4'd8;
  localparam logic [3:0] PH_ROW_EL   = 4'd9;
  localparam logic [3:0] PH_MEMWR    = 4'd10;

  // display commands
  localparam logic [7:0] CMD_COL     = 8'h2A;
  localparam logic [7:0] CMD_PAGE    = 8'h2B;
  localparam logic [7:0] CMD_MEMWR   = 8'h2C;
  localparam logic [7:0] CMD_ACCESS  = 8'h36;
  localparam logic [7:0] CMD_INV_OFF = 8'h20;
  localparam logic [7:0] CMD_INV_ON  = 8'h21;

  // access control bits
  localparam logic [7:0] ACC_BGR = 8'h08;
  localparam logic [7:0] ACC_MX  = 8'h40;
  localparam logic [7:0] ACC_MY  = 8'h80;
  localparam logic [7:0] ACC_MV  = 8'h20;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] x_pos;
    logic [15:0] y_pos;
    logic [15:0] width_px;
    logic [15:0] height_px;
    logic [15:0] fill_color;
    logic [1:0]  rotation_sel;
    logic        invert_on;
  } in_word_t;

  typedef struct packed {
    logic        write_valid;
    logic        write_is_command;
    logic [15:0] write_value;
    logic        last_write;
    logic        refused;
    logic        busy_res;
  } out_word_t;

  function automatic logic [7:0] access_value(input logic [1:0] rot);
    logic [7:0] v;
    unique case (rot)
      2'd0:    v = ACC_BGR | ACC_MX;
      2'd1:    v = ACC_BGR | ACC_MV;
      2'd2:    v = ACC_BGR | ACC_MY;
      default: v = ACC_BGR | ACC_MX | ACC_MY | ACC_MV;
    endcase
    return v;
  endfunction

  function automatic logic [15:0] hi_byte(input coord_t c);
    logic [15:0] v;
    v = 16'(c);
    return v >> 8;
  endfunction

  function automatic logic [15:0] lo_byte(input coord_t c);
    logic [15:0] v;
    v = 16'(c);
    return v & 16'h00FF;
  endfunction

endpackage

[src/lwf_if.sv]
// ----------------------------------------------------------------------------
// lwf channel interfaces
// Valid/ready channels for request words and bus write result words.
// ----------------------------------------------------------------------------
interface lwf_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [15:0] x_pos;
  logic [15:0] y_pos;
  logic [15:0] width_px;
  logic [15:0] height_px;
  logic [15:0] fill_color;
  logic [1:0]  rotation_sel;
  logic        invert_on;

  modport source (output valid, req_type, x_pos, y_pos, width_px, height_px,
                  fill_color, rotation_sel, invert_on, input ready);
  modport sink (input valid, req_type, x_pos, y_pos, width_px, height_px,
                fill_color, rotation_sel, invert_on, output ready);
endinterface

interface lwf_out_if;
  logic        valid;
  logic        ready;
  logic        write_valid;
  logic        write_is_command;
  logic [15:0] write_value;
  logic        last_write;
  logic        refused;
  logic        busy_res;

  modport source (output valid, write_valid, write_is_command, write_value, last_write,
                  refused, busy_res, input ready);
  modport sink (input valid, write_valid, write_is_command, write_value, last_write,
                refused, busy_res, output ready);
endinterface

[src/lwf_seq.sv]
// ----------------------------------------------------------------------------
// lwf_seq
// Operation state and write sequencer: takes one request word per step and
// gives the result word for it, updating the pending operation.
// ----------------------------------------------------------------------------
module lwf_seq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  lwf_pkg::in_word_t in_word,
  output lwf_pkg::out_word_t res
);
  import lwf_pkg::*;

  localparam logic [16:0] LAST_COL = 17'(SCREEN_WIDTH - 1);
  localparam logic [16:0] LAST_ROW = 17'(SCREEN_HEIGHT - 1);

  logic       active_r, active_nxt;
  logic [1:0] kind_r, kind_nxt;
  logic [3:0] phase_r, phase_nxt;
  logic       mul_pend_r;
  logic       fill_load;

  coord_t     col_start_r, col_start_nxt;
  coord_t     col_end_r, col_end_nxt;
  coord_t     row_start_r, row_start_nxt;
  coord_t     row_end_r, row_end_nxt;
  logic [15:0] pixel_r, pixel_nxt;
  logic [7:0] pending_r, pending_nxt;
  pix_cnt_t   pixels_left_r, pixels_left_nxt;

  logic [16:0] x_end, y_end;
  coord_t      col_span, row_span;
  pix_cnt_t    pix_total;

  // end corner summed without wrap, then clipped
  always_comb begin
    x_end = 17'(in_word.x_pos) + 17'(in_word.width_px) - 17'd1;
    y_end = 17'(in_word.y_pos) + 17'(in_word.height_px) - 17'd1;
    if (x_end > LAST_COL) x_end = LAST_COL;
    if (y_end > LAST_ROW) y_end = LAST_ROW;
  end

  // pixel count is formed in the cycle after a fill is taken, while the
  // first colour word is still ahead
  assign col_span  = coord_t'(col_end_r - col_start_r + coord_t'(1));
  assign row_span  = coord_t'(row_end_r - row_start_r + coord_t'(1));
  assign pix_total = pix_cnt_t'(pix_cnt_t'(col_span) * pix_cnt_t'(row_span));

  always_comb begin
    active_nxt      = active_r;
    kind_nxt        = kind_r;
    phase_nxt       = phase_r;
    col_start_nxt   = col_start_r;
    col_end_nxt     = col_end_r;
    row_start_nxt   = row_start_r;
    row_end_nxt     = row_end_r;
    pixel_nxt       = pixel_r;
    pending_nxt     = pending_r;
    pixels_left_nxt = pixels_left_r;
    fill_load       = 1'b0;
    res             = '0;

    if (in_word.req_type == REQ_TICK) begin
      if (active_r) begin
        res.write_valid = 1'b1;
        if (kind_r == KIND_FILL) begin
          phase_nxt = phase_r + 4'd1;
          unique case (phase_r)
            PH_COL_CMD: begin
              res.write_is_command = 1'b1;
              res.write_value      = {8'h00, CMD_COL};
            end
            PH_COL_SH:   res.write_value = hi_byte(col_start_r);
            PH_COL_SL:   res.write_value = lo_byte(col_start_r);
            PH_COL_EH:   res.write_value = hi_byte(col_end_r);
            PH_COL_EL:   res.write_value = lo_byte(col_end_r);
            PH_PAGE_CMD: begin
              res.write_is_command = 1'b1;
              res.write_value      = {8'h00, CMD_PAGE};
            end
            PH_ROW_SH:   res.write_value = hi_byte(row_start_r);
            PH_ROW_SL:   res.write_value = lo_byte(row_start_r);
            PH_ROW_EH:   res.write_value = hi_byte(row_end_r);
            PH_ROW_EL:   res.write_value = lo_byte(row_end_r);
            PH_MEMWR: begin
              res.write_is_command = 1'b1;
              res.write_value      = {8'h00, CMD_MEMWR};
            end
            default: begin
              // colour words
              phase_nxt       = phase_r;
              res.write_value = pixel_r;
              if (pixels_left_r <= pix_cnt_t'(1)) begin
                pixels_left_nxt = '0;
                res.last_write  = 1'b1;
              end else begin
                pixels_left_nxt = pixels_left_r - pix_cnt_t'(1);
              end
            end
          endcase
        end else if (kind_r == KIND_ROT) begin
          if (phase_r == PH_COL_CMD) begin
            res.write_is_command = 1'b1;
            res.write_value      = {8'h00, CMD_ACCESS};
            phase_nxt            = 4'd1;
          end else begin
            res.write_value = {8'h00, pending_r};
            res.last_write  = 1'b1;
          end
        end else begin
          res.write_is_command = 1'b1;
          res.write_value      = {8'h00, pending_r};
          res.last_write       = 1'b1;
        end
        if (res.last_write) begin
          active_nxt = 1'b0;
          phase_nxt  = PH_COL_CMD;
        end
      end
    end else if (active_r) begin
      res.refused = 1'b1;
    end else if (in_word.req_type == REQ_FILL) begin
      if (in_word.x_pos >= 16'(SCREEN_WIDTH) || in_word.y_pos >= 16'(SCREEN_HEIGHT) ||
          in_word.width_px == 16'd0 || in_word.height_px == 16'd0) begin
        res.refused = 1'b1;
      end else begin
        col_start_nxt = coord_t'(in_word.x_pos);
        col_end_nxt   = coord_t'(x_end);
        row_start_nxt = coord_t'(in_word.y_pos);
        row_end_nxt   = coord_t'(y_end);
        pixel_nxt     = in_word.fill_color;
        kind_nxt      = KIND_FILL;
        phase_nxt     = PH_COL_CMD;
        active_nxt    = 1'b1;
        fill_load     = 1'b1;
      end
    end else begin
      if (in_word.req_type == REQ_ROT) begin
        pending_nxt = access_value(in_word.rotation_sel);
        kind_nxt    = KIND_ROT;
      end else begin
        pending_nxt = in_word.invert_on ? CMD_INV_ON : CMD_INV_OFF;
        kind_nxt    = KIND_INV;
      end
      phase_nxt  = PH_COL_CMD;
      active_nxt = 1'b1;
    end

    res.busy_res = active_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r   <= 1'b0;
      kind_r     <= KIND_FILL;
      phase_r    <= PH_COL_CMD;
      mul_pend_r <= 1'b0;
    end else begin
      mul_pend_r <= step && fill_load;
      if (step) begin
        active_r <= active_nxt;
        kind_r   <= kind_nxt;
        phase_r  <= phase_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      col_start_r <= col_start_nxt;
      col_end_r   <= col_end_nxt;
      row_start_r <= row_start_nxt;
      row_end_r   <= row_end_nxt;
      pixel_r     <= pixel_nxt;
      pending_r   <= pending_nxt;
    end
    if (mul_pend_r) begin
      pixels_left_r <= pix_total;
    end else if (step) begin
      pixels_left_r <= pixels_left_nxt;
    end
  end

endmodule

[src/lcd_window_fill_command_engine_top.sv]
// ----------------------------------------------------------------------------
// lcd_window_fill_command_engine_top
// Turns fill, orientation and inversion requests into a display bus write
// stream, one bus write per tick word taken while an operation is pending.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch takes request words: fill, tick, orientation or inversion. Every
//   accepted word gives exactly one result word on out_ch. A request taken
//   while idle is answered with busy set and no write; the writes follow on
//   later tick words, one each, the last one flagged. A request arriving
//   while an operation is pending, off screen or of zero size is refused.
//   The result word is registered at the edge that takes the request.
//   Throughput is one word per cycle; the output register frees at the edge
//   its word is taken, so in_ch.ready stays high while out_ch is taken every
//   cycle. A fill's pixel count is multiplied out in the cycle after it is
//   taken, ahead of its first colour write.
//   Synchronous reset clears the pending operation and the output valid flag.
//   When the receiver stalls, the result word holds and in_ch.ready drops
//   until it is taken.
// ----------------------------------------------------------------------------
module lcd_window_fill_command_engine_top (
  input logic       clk,
  input logic       rst_n,
  lwf_in_if.sink    in_ch,
  lwf_out_if.source out_ch
);
  import lwf_pkg::*;

  in_word_t  in_word;
  out_word_t res;
  out_word_t out_r;
  logic      out_valid_r;
  logic      in_ready;
  logic      step;

  assign in_ready    = !out_valid_r || out_ch.ready;
  assign in_ch.ready = in_ready;
  assign step        = in_ch.valid && in_ready;

  assign in_word.req_type     = in_ch.req_type;
  assign in_word.x_pos        = in_ch.x_pos;
  assign in_word.y_pos        = in_ch.y_pos;
  assign in_word.width_px     = in_ch.width_px;
  assign in_word.height_px    = in_ch.height_px;
  assign in_word.fill_color   = in_ch.fill_color;
  assign in_word.rotation_sel = in_ch.rotation_sel;
  assign in_word.invert_on    = in_ch.invert_on;

  lwf_seq u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .in_word (in_word),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_ready) begin
      out_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_r <= res;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.write_valid      = out_r.write_valid;
  assign out_ch.write_is_command = out_r.write_is_command;
  assign out_ch.write_value      = out_r.write_value;
  assign out_ch.last_write       = out_r.last_write;
  assign out_ch.refused          = out_r.refused;
  assign out_ch.busy_res         = out_r.busy_res;

  a_no_write_on_refuse : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_r.refused && out_r.write_valid))
    else $error("refused word carries a bus write");

  a_last_ends_op : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.last_write |-> out_r.write_valid && !out_r.busy_res)
    else $error("last write leaves operation pending");

  a_stall_blocks_input : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |-> !in_ch.ready)
    else $error("input taken while result word stalled");

  a_step_loads_output : assert property (@(posedge clk) disable iff (!rst_n)
    step |=> out_valid_r)
    else $error("accepted word gave no result");

endmodule

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the window fill command engine. Request words go in
// with random gaps and results are taken with random stalls. A behavioural
// model of the write sequencer predicts each result word: window commands,
// clipped coordinates, colour writes, refusals and the busy flag.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import lwf_pkg::*;

  localparam int RANDOM_WORDS    = 1030;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int SETTLE_CYCLES   = 4;
  localparam int FILL_PHASE_LAST = 11;

  logic clk;
  logic rst_n;

  lwf_in_if  in_ch ();
  lwf_out_if out_ch ();

  lcd_window_fill_command_engine_top u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // sequencer model state
  logic       op_busy;
  logic [1:0] op_code;
  logic [3:0] op_phase;
  coord_t     win_col_first;
  coord_t     win_col_last;
  coord_t     win_row_first;
  coord_t     win_row_last;
  logic [15:0] win_colour;
  pix_cnt_t   pixels_remaining;
  logic [7:0] param_byte;

  out_word_t expected_words[$];

  int  errors;
  int  words_sent;
  int  fills_started;
  int  other_ops_started;
  int  refusals_seen;
  int  bus_writes_seen;
  int  quiet_cycles;
  bit  steady_flow;

  function automatic out_word_t predict_bus_write(input in_word_t w);
    out_word_t r;
    int x_end;
    int y_end;
    r = '0;
    if (w.req_type == REQ_TICK) begin
      if (op_busy) begin
        r.write_valid = 1'b1;
        bus_writes_seen++;
        if (op_code == KIND_FILL) begin
          case (op_phase)
            PH_COL_CMD: begin
              r.write_is_command = 1'b1;
              r.write_value      = 16'(CMD_COL);
            end
            PH_COL_SH:   r.write_value = 16'(win_col_first) >> 8;
            PH_COL_SL:   r.write_value = 16'(win_col_first) & 16'h00FF;
            PH_COL_EH:   r.write_value = 16'(win_col_last) >> 8;
            PH_COL_EL:   r.write_value = 16'(win_col_last) & 16'h00FF;
            PH_PAGE_CMD: begin
              r.write_is_command = 1'b1;
              r.write_value      = 16'(CMD_PAGE);
            end
            PH_ROW_SH:   r.write_value = 16'(win_row_first) >> 8;
            PH_ROW_SL:   r.write_value = 16'(win_row_first) & 16'h00FF;
            PH_ROW_EH:   r.write_value = 16'(win_row_last) >> 8;
            PH_ROW_EL:   r.write_value = 16'(win_row_last) & 16'h00FF;
            PH_MEMWR: begin
              r.write_is_command = 1'b1;
              r.write_value      = 16'(CMD_MEMWR);
            end
            default: begin
              r.write_value = win_colour;
              if (pixels_remaining <= 1) begin
                pixels_remaining = '0;
                r.last_write     = 1'b1;
              end else begin
                pixels_remaining = pixels_remaining - 1'b1;
              end
            end
          endcase
          if (op_phase < FILL_PHASE_LAST) op_phase = op_phase + 1'b1;
        end else if (op_code == KIND_ROT) begin
          if (op_phase == PH_COL_CMD) begin
            r.write_is_command = 1'b1;
            r.write_value      = 16'(CMD_ACCESS);
            op_phase           = PH_COL_SH;
          end else begin
            r.write_value = 16'(param_byte);
            r.last_write  = 1'b1;
          end
        end else begin
          r.write_is_command = 1'b1;
          r.write_value      = 16'(param_byte);
          r.last_write       = 1'b1;
        end
        if (r.last_write) begin
          op_busy  = 1'b0;
          op_phase = PH_COL_CMD;
        end
      end
    end else if (op_busy) begin
      r.refused = 1'b1;
      refusals_seen++;
    end else if (w.req_type == REQ_FILL) begin
      if (w.x_pos >= SCREEN_WIDTH || w.y_pos >= SCREEN_HEIGHT ||
          w.width_px == 0 || w.height_px == 0) begin
        r.refused = 1'b1;
        refusals_seen++;
      end else begin
        // end corner summed wide, so no wrap before the clip
        x_end = int'(w.x_pos) + int'(w.width_px) - 1;
        y_end = int'(w.y_pos) + int'(w.height_px) - 1;
        if (x_end >= SCREEN_WIDTH)  x_end = SCREEN_WIDTH - 1;
        if (y_end >= SCREEN_HEIGHT) y_end = SCREEN_HEIGHT - 1;
        win_col_first    = coord_t'(w.x_pos);
        win_col_last     = coord_t'(x_end);
        win_row_first    = coord_t'(w.y_pos);
        win_row_last     = coord_t'(y_end);
        win_colour       = w.fill_color;
        pixels_remaining = pix_cnt_t'((x_end - int'(w.x_pos) + 1) *
                                      (y_end - int'(w.y_pos) + 1));
        op_code          = KIND_FILL;
        op_phase         = PH_COL_CMD;
        op_busy          = 1'b1;
        fills_started++;
      end
    end else begin
      if (w.req_type == REQ_ROT) begin
        case (w.rotation_sel)
          2'd0:    param_byte = ACC_BGR | ACC_MX;
          2'd1:    param_byte = ACC_BGR | ACC_MV;
          2'd2:    param_byte = ACC_BGR | ACC_MY;
          default: param_byte = ACC_BGR | ACC_MX | ACC_MY | ACC_MV;
        endcase
        op_code = KIND_ROT;
      end else begin
        param_byte = w.invert_on ? CMD_INV_ON : CMD_INV_OFF;
        op_code    = KIND_INV;
      end
      op_phase = PH_COL_CMD;
      op_busy  = 1'b1;
      other_ops_started++;
    end
    r.busy_res = op_busy;
    return r;
  endfunction

  function automatic in_word_t random_word();
    in_word_t w;
    w.req_type     = 2'($urandom_range(0, 3));
    w.x_pos        = 16'($urandom);
    w.y_pos        = 16'($urandom);
    w.width_px     = 16'($urandom);
    w.height_px    = 16'($urandom);
    w.fill_color   = 16'($urandom);
    w.rotation_sel = 2'($urandom_range(0, 3));
    w.invert_on    = 1'($urandom_range(0, 1));
    return w;
  endfunction

  task automatic send_word(input in_word_t w);
    int gap;
    gap = steady_flow ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.req_type     <= w.req_type;
    in_ch.x_pos        <= w.x_pos;
    in_ch.y_pos        <= w.y_pos;
    in_ch.width_px     <= w.width_px;
    in_ch.height_px    <= w.height_px;
    in_ch.fill_color   <= w.fill_color;
    in_ch.rotation_sel <= w.rotation_sel;
    in_ch.invert_on    <= w.invert_on;
    in_ch.valid        <= 1'b1;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    expected_words.push_back(predict_bus_write(w));
    words_sent++;
  endtask

  // tick until the pending operation has finished, with stray requests mixed in when with_noise is set
  task automatic drain_operation(input bit with_noise);
    in_word_t w;
    while (op_busy) begin
      w = random_word();
      if (!(with_noise && $urandom_range(0, 7) == 0)) w.req_type = REQ_TICK;
      send_word(w);
    end
  endtask

  task automatic test_refusals();
    in_word_t w;
    w = random_word();
    w.req_type = REQ_TICK;
    send_word(w);
    w = random_word();
    w.req_type  = REQ_FILL;
    w.x_pos     = 16'd0;
    w.y_pos     = 16'd0;
    w.width_px  = 16'd0;
    w.height_px = 16'd5;
    send_word(w);
    w.width_px  = 16'd3;
    w.height_px = 16'd0;
    send_word(w);
    w.height_px = 16'd1;
    w.x_pos     = 16'(SCREEN_WIDTH);
    send_word(w);
    w.x_pos     = 16'd0;
    w.y_pos     = 16'hFFFF;
    send_word(w);
  endtask

  task automatic test_clipped_corner_fill();
    in_word_t w;
    w = random_word();
    w.req_type   = REQ_FILL;
    w.x_pos      = 16'(SCREEN_WIDTH - 1);
    w.y_pos      = 16'(SCREEN_HEIGHT - 1);
    w.width_px   = 16'hFFFF;
    w.height_px  = 16'hFFFF;
    w.fill_color = 16'hFFFF;
    send_word(w);
    // an orientation request during the fill must bounce
    w.req_type = REQ_ROT;
    send_word(w);
    drain_operation(1'b0);
  endtask

  task automatic test_orientation_and_inversion();
    in_word_t w;
    w = random_word();
    w.req_type     = REQ_ROT;
    w.rotation_sel = 2'd3;
    send_word(w);
    drain_operation(1'b0);
    w.req_type  = REQ_INV;
    w.invert_on = 1'b1;
    send_word(w);
    drain_operation(1'b0);
  endtask

  task automatic test_random_traffic();
    in_word_t w;
    int pick;
    int target;
    target = words_sent + RANDOM_WORDS;
    while (words_sent < target) begin
      steady_flow = ($urandom_range(0, 4) == 0);
      pick = $urandom_range(0, 19);
      w = random_word();
      w.req_type = REQ_FILL;
      w.x_pos    = 16'($urandom_range(0, SCREEN_WIDTH - 1));
      w.y_pos    = 16'($urandom_range(0, SCREEN_HEIGHT - 1));
      case (pick)
        0, 1: begin
          case ($urandom_range(0, 3))
            0:       w.x_pos     = 16'($urandom_range(SCREEN_WIDTH, 65535));
            1:       w.y_pos     = 16'($urandom_range(SCREEN_HEIGHT, 65535));
            2:       w.width_px  = 16'd0;
            default: w.height_px = 16'd0;
          endcase
        end
        2, 3: w.req_type = REQ_ROT;
        4, 5: w.req_type = REQ_INV;
        6:    w.req_type = REQ_TICK;
        7:    w = random_word();
        8: begin
          // hug the right or bottom edge with a wide size so the corner clips
          if ($urandom_range(0, 1)) begin
            w.x_pos     = 16'(SCREEN_WIDTH - $urandom_range(1, 3));
            w.width_px  = 16'($urandom_range(1, 65535));
            w.height_px = 16'($urandom_range(1, 3));
          end else begin
            w.y_pos     = 16'(SCREEN_HEIGHT - $urandom_range(1, 3));
            w.height_px = 16'($urandom_range(1, 65535));
            w.width_px  = 16'($urandom_range(1, 3));
          end
        end
        9: begin
          w.width_px  = 16'($urandom_range(1, 16));
          w.height_px = 16'($urandom_range(1, 16));
        end
        default: begin
          w.width_px  = 16'($urandom_range(1, 4));
          w.height_px = 16'($urandom_range(1, 4));
        end
      endcase
      send_word(w);
      drain_operation(1'b1);
    end
    steady_flow = 1'b0;
  endtask

  function automatic void check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $error("%s expected %0h got %0h", name, exp_v, act_v);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    out_word_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_words.size() == 0) begin
        $error("result word with nothing expected");
        errors++;
      end else begin
        e = expected_words.pop_front();
        check_field("write_valid", e.write_valid, out_ch.write_valid);
        check_field("write_is_command", e.write_is_command, out_ch.write_is_command);
        check_field("write_value", e.write_value, out_ch.write_value);
        check_field("last_write", e.last_write, out_ch.last_write);
        check_field("refused", e.refused, out_ch.refused);
        check_field("busy_res", e.busy_res, out_ch.busy_res);
      end
    end
  end

  // receiver stalls
  initial begin
    int stall;
    forever begin
      stall = steady_flow ? 0 : $urandom_range(0, 8);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    errors            = 0;
    words_sent        = 0;
    fills_started     = 0;
    other_ops_started = 0;
    refusals_seen     = 0;
    bus_writes_seen   = 0;
    steady_flow       = 1'b0;
    op_busy           = 1'b0;
    op_code           = KIND_FILL;
    op_phase          = PH_COL_CMD;
    win_col_first     = '0;
    win_col_last      = '0;
    win_row_first     = '0;
    win_row_last      = '0;
    win_colour        = '0;
    pixels_remaining  = '0;
    param_byte        = '0;
    rst_n              <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.req_type     <= REQ_TICK;
    in_ch.x_pos        <= '0;
    in_ch.y_pos        <= '0;
    in_ch.width_px     <= '0;
    in_ch.height_px    <= '0;
    in_ch.fill_color   <= '0;
    in_ch.rotation_sel <= '0;
    in_ch.invert_on    <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_refusals();
    test_clipped_corner_fill();
    test_orientation_and_inversion();
    test_random_traffic();

    in_ch.valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("%0d request words sent: %0d fills and %0d orientation/inversion ops started",
             words_sent, fills_started, other_ops_started);
    $display("%0d requests refused, %0d bus writes checked", refusals_seen, bus_writes_seen);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[sim.f]
src/lwf_pkg.sv
src/lwf_if.sv
src/lwf_seq.sv
src/lcd_window_fill_command_engine_top.sv
tb/testbench.sv
